// File: src/shell_command_tokenizer_top_macros.svh
// ---------------------------------------------------------------------------
// Shell command tokenizer assertion macros
// Concurrent check helpers, clocked on i_clk, quiet while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SHELL_COMMAND_TOKENIZER_TOP_MACROS_SVH
`define SHELL_COMMAND_TOKENIZER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define SCT_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("sct assertion failed");
// Next-cycle implication.
`define SCT_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("sct assertion failed");
`else
`define SCT_ASSERT_NOW(lbl, pre, post)
`define SCT_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// File: src/sct_pkg.sv
// ---------------------------------------------------------------------------
// Shell command tokenizer package
// Shared types, byte codes, token kinds and lexer modes.
// ---------------------------------------------------------------------------
package sct_pkg;

    // most results one input word can cause
    localparam int unsigned MaxRes        = 3;
    localparam int unsigned ResCntW       = $clog2(MaxRes + 1);
    localparam int unsigned ResIdxW       = $clog2(MaxRes);
    localparam int unsigned QueueDepthDef = 4;

    localparam logic [7:0]  WordLimitRst  = 8'd48;
    localparam int unsigned ApbAddrW      = 3;
    localparam int unsigned ApbDataW      = 32;
    localparam logic [0:0]  RegWordLimit  = 1'b0;

    localparam logic [7:0] ChNul  = 8'h00;
    localparam logic [7:0] ChTab  = 8'h09;
    localparam logic [7:0] ChLf   = 8'h0A;
    localparam logic [7:0] ChCr   = 8'h0D;
    localparam logic [7:0] ChSp   = 8'h20;
    localparam logic [7:0] ChDq   = 8'h22;
    localparam logic [7:0] ChHash = 8'h23;
    localparam logic [7:0] ChSq   = 8'h27;
    localparam logic [7:0] ChSemi = 8'h3B;
    localparam logic [7:0] ChLt   = 8'h3C;
    localparam logic [7:0] ChGt   = 8'h3E;
    localparam logic [7:0] ChBsl  = 8'h5C;
    localparam logic [7:0] ChPipe = 8'h7C;

    typedef enum logic [2:0] {
        LexBetween,
        LexWord,
        LexSq,
        LexDq,
        LexDqBsl,
        LexBsl,
        LexComment,
        LexDiscard
    } t_lex_mode;

    typedef enum logic [2:0] {
        KindChar,
        KindWordEnd,
        KindPipe,
        KindIn,
        KindOut,
        KindCmdEnd,
        KindTooMany,
        KindOpenQuote
    } t_tok_kind;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_line;
    } t_tok_in;

    typedef struct packed {
        logic [2:0] token_kind;
        logic [7:0] char_out;
        logic [7:0] token_count;
        logic       last_of_run;
    } t_tok_out;

    // one result before serialization
    typedef struct packed {
        t_tok_kind  kind;
        logic [7:0] ch;
        logic [7:0] cnt;
    } t_tok_res;

    // all results of one input word
    typedef struct packed {
        logic [ResCntW-1:0]         num;
        t_tok_res [MaxRes-1:0]      res;
    } t_tok_bundle;

    typedef struct packed {
        logic        valid;
        t_tok_bundle bundle;
    } t_q_push;

    typedef struct packed {
        logic        valid;
        t_tok_bundle bundle;
    } t_q_head;

    function automatic t_tok_res mk_res(t_tok_kind k, logic [7:0] ch, logic [7:0] cnt);
        t_tok_res r;
        r.kind = k;
        r.ch   = ch;
        r.cnt  = cnt;
        return r;
    endfunction

endpackage

// File: src/shell_command_tokenizer_top.sv
// ---------------------------------------------------------------------------
// Shell command tokenizer
// Splits a command line, one byte per word, into a stream of token results.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  -------   ---------  ----------------------  --------------------------
//  in        input      i_in_valid/o_in_ready   i_in_word  (t_tok_in)
//  out       output     o_out_valid/i_out_ready o_out_word (t_tok_out)
//  cfg       input      APB psel/penable/pready paddr, pwdata, prdata
//
//  Rates: one input word per cycle while o_in_ready is high. An input word
//    causing n results (0 to 3) pushes one bundle that the serializer walks
//    result by result; words with no result push nothing. Results leave at one per cycle while i_out_ready is high.
//  The bundle queue (QUEUE_DEPTH entries) absorbs bursts of multi-result
//    words; o_in_ready drops only when it is full.
//  Reset: synchronous, active low; clears lexer mode, token counter, queue
//    pointers and output valid, and loads word_limit with 48. No clear pass.
//  Stalls: i_out_ready low holds the output register; the front end keeps
//    accepting until the queue fills.
// ---------------------------------------------------------------------------
`include "shell_command_tokenizer_top_macros.svh"

module shell_command_tokenizer_top
    import sct_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input words
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_tok_in             i_in_word,
    // result words
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_tok_out            o_out_word,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [ApbDataW-1:0] pwdata,
    output logic [ApbDataW-1:0] prdata,
    output logic                pready
);

    logic [7:0] r_word_limit;
    logic       w_fire;
    logic       w_q_full;
    logic       w_pop;
    t_q_push    w_push;
    t_q_head    w_head;
    logic       w_reg_hit;

    // ---- register port ----
    // Single register at byte 0; low address bits ignored.
    assign pready    = 1'b1;
    assign w_reg_hit = (paddr[ApbAddrW-1:2] == RegWordLimit);
    assign prdata    = w_reg_hit ? {{(ApbDataW-8){1'b0}}, r_word_limit} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_limit <= WordLimitRst;
        end else if (psel && penable && pwrite && pready && w_reg_hit) begin
            r_word_limit <= pwdata[7:0];
        end
    end

    // ---- front end: lexer ----
    // Input is taken whenever a bundle slot is free, regardless of the
    // output side.
    assign o_in_ready = !w_q_full;
    assign w_fire     = i_in_valid && o_in_ready;

    sct_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word_limit (r_word_limit),
        .i_fire       (w_fire),
        .i_in_word    (i_in_word),
        .o_push       (w_push)
    );

    // ---- bundle queue ----
    sct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    // ---- back end: serializer and output register ----
    sct_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // ---- checks ----
    // count field is only carried by a command end
    `SCT_ASSERT_NOW(a_cnt_only_cmd_end, o_out_valid && (o_out_word.token_kind != KindCmdEnd), o_out_word.token_count == 8'd0)
    // byte field only on word bytes and open quote errors
    `SCT_ASSERT_NOW(a_char_only_bytes, o_out_valid && (o_out_word.token_kind != KindChar) && (o_out_word.token_kind != KindOpenQuote), o_out_word.char_out == 8'd0)
    // the queue can only fill through a push
    `SCT_ASSERT_NEXT(a_ready_drop_push, o_in_ready && !w_push.valid, o_in_ready)
    // empty bundles never enter the queue
    `SCT_ASSERT_NOW(a_push_nonempty, w_push.valid, w_push.bundle.num != '0)

endmodule

// File: src/sct_front.sv
// ---------------------------------------------------------------------------
// Tokenizer front end
// Lexer mode and token counter; turns one input word into a result bundle.
// ---------------------------------------------------------------------------
module sct_front
    import sct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_word_limit,
    input  logic       i_fire,
    input  t_tok_in    i_in_word,
    output t_q_push    o_push
);

    t_lex_mode   r_mode, n_mode;
    logic [7:0]  r_cnt, n_cnt;
    t_tok_bundle w_bundle;

    logic [7:0] c;
    logic       eol, blank, special;

    assign c       = i_in_word.char_in;
    assign eol     = i_in_word.end_of_line || (c == ChNul);
    assign blank   = (c == ChSp) || (c == ChTab) || (c == ChLf) || (c == ChCr);
    assign special = (c == ChSemi) || (c == ChPipe) || (c == ChLt) || (c == ChGt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= LexBetween;
            r_cnt  <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
        end
    end

    always_comb begin : p_lex
        logic [ResCntW-1:0] k;
        logic               do_between;
        logic               do_word;
        logic               do_dq;

        k          = '0;
        do_between = 1'b0;
        do_word    = 1'b0;
        do_dq      = 1'b0;
        n_mode     = r_mode;
        n_cnt      = r_cnt;
        for (int i = 0; i < MaxRes; i++) begin
            w_bundle.res[i] = mk_res(KindChar, ChNul, 8'd0);
        end

        if (eol) begin
            case (r_mode)
                LexBetween, LexComment: begin
                    w_bundle.res[k] = mk_res(KindCmdEnd, ChNul, r_cnt);
                    k = k + 1'b1;
                end
                LexWord: begin
                    w_bundle.res[k] = mk_res(KindWordEnd, ChNul, 8'd0);
                    k = k + 1'b1;
                    w_bundle.res[k] = mk_res(KindCmdEnd, ChNul, r_cnt);
                    k = k + 1'b1;
                end
                LexBsl: begin
                    // trailing backslash stays literal
                    w_bundle.res[k] = mk_res(KindChar, ChBsl, 8'd0);
                    k = k + 1'b1;
                    w_bundle.res[k] = mk_res(KindWordEnd, ChNul, 8'd0);
                    k = k + 1'b1;
                    w_bundle.res[k] = mk_res(KindCmdEnd, ChNul, r_cnt);
                    k = k + 1'b1;
                end
                LexSq: begin
                    w_bundle.res[k] = mk_res(KindOpenQuote, ChSq, 8'd0);
                    k = k + 1'b1;
                end
                LexDq: begin
                    w_bundle.res[k] = mk_res(KindOpenQuote, ChDq, 8'd0);
                    k = k + 1'b1;
                end
                LexDqBsl: begin
                    w_bundle.res[k] = mk_res(KindChar, ChBsl, 8'd0);
                    k = k + 1'b1;
                    w_bundle.res[k] = mk_res(KindOpenQuote, ChDq, 8'd0);
                    k = k + 1'b1;
                end
                default: begin
                end
            endcase
            n_mode = LexBetween;
            n_cnt  = '0;
        end else begin
            case (r_mode)
                LexBetween: do_between = 1'b1;
                LexWord: begin
                    if (blank || special) begin
                        w_bundle.res[k] = mk_res(KindWordEnd, ChNul, 8'd0);
                        k = k + 1'b1;
                        n_mode = LexBetween;
                        do_between = !blank;
                    end else begin
                        do_word = 1'b1;
                    end
                end
                LexSq: begin
                    if (c == ChSq) begin
                        n_mode = LexWord;
                    end else begin
                        w_bundle.res[k] = mk_res(KindChar, c, 8'd0);
                        k = k + 1'b1;
                    end
                end
                LexDq: do_dq = 1'b1;
                LexDqBsl: begin
                    n_mode = LexDq;
                    if (c == ChDq || c == ChBsl) begin
                        w_bundle.res[k] = mk_res(KindChar, c, 8'd0);
                        k = k + 1'b1;
                    end else begin
                        w_bundle.res[k] = mk_res(KindChar, ChBsl, 8'd0);
                        k = k + 1'b1;
                        do_dq = 1'b1;
                    end
                end
                LexBsl: begin
                    w_bundle.res[k] = mk_res(KindChar, c, 8'd0);
                    k = k + 1'b1;
                    n_mode = LexWord;
                end
                default: begin
                end
            endcase

            if (do_between) begin
                if (blank) begin
                end else if (c == ChHash) begin
                    n_mode = LexComment;
                end else if (c == ChSemi) begin
                    w_bundle.res[k] = mk_res(KindCmdEnd, ChNul, r_cnt);
                    k = k + 1'b1;
                    n_cnt = '0;
                end else if (r_cnt == i_word_limit) begin
                    w_bundle.res[k] = mk_res(KindTooMany, ChNul, 8'd0);
                    k = k + 1'b1;
                    n_mode = LexDiscard;
                end else begin
                    n_cnt = r_cnt + 8'd1;
                    if (c == ChPipe) begin
                        w_bundle.res[k] = mk_res(KindPipe, ChNul, 8'd0);
                        k = k + 1'b1;
                    end else if (c == ChLt) begin
                        w_bundle.res[k] = mk_res(KindIn, ChNul, 8'd0);
                        k = k + 1'b1;
                    end else if (c == ChGt) begin
                        w_bundle.res[k] = mk_res(KindOut, ChNul, 8'd0);
                        k = k + 1'b1;
                    end else begin
                        n_mode  = LexWord;
                        do_word = 1'b1;
                    end
                end
            end

            if (do_word) begin
                if (c == ChSq) begin
                    n_mode = LexSq;
                end else if (c == ChDq) begin
                    n_mode = LexDq;
                end else if (c == ChBsl) begin
                    n_mode = LexBsl;
                end else begin
                    w_bundle.res[k] = mk_res(KindChar, c, 8'd0);
                    k = k + 1'b1;
                end
            end

            if (do_dq) begin
                if (c == ChDq) begin
                    n_mode = LexWord;
                end else if (c == ChBsl) begin
                    n_mode = LexDqBsl;
                end else begin
                    w_bundle.res[k] = mk_res(KindChar, c, 8'd0);
                    k = k + 1'b1;
                end
            end
        end

        w_bundle.num = k;
    end

    assign o_push.valid  = i_fire && (w_bundle.num != '0);
    assign o_push.bundle = w_bundle;

endmodule

// File: src/sct_queue.sv
// ---------------------------------------------------------------------------
// Tokenizer bundle queue
// Short FIFO of result bundles between front end and serializer.
// ---------------------------------------------------------------------------
module sct_queue
    import sct_pkg::*;
#(
    parameter int unsigned DEPTH = QueueDepthDef
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_push i_push,
    output logic    o_full,
    input  logic    i_pop,
    output t_q_head o_head
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    t_tok_bundle       r_mem [DEPTH];
    logic [PtrW-1:0]   r_wr, r_rd;
    logic [CntW-1:0]   r_count;
    logic              w_do_push, w_do_pop;

    assign o_full       = (r_count == CntFull);
    assign w_do_push    = i_push.valid && !o_full;
    assign w_do_pop     = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.bundle = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_push.bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == PtrLast) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PtrLast) ? '0 : r_rd + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: src/sct_back.sv
// ---------------------------------------------------------------------------
// Tokenizer serializer
// Walks the head bundle one result per cycle into the output register while it is empty or i_out_ready is high.
// ---------------------------------------------------------------------------
module sct_back
    import sct_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_q_head  i_head,
    output logic     o_pop,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_tok_out o_out_word
);

    logic [ResIdxW-1:0] r_idx;
    logic               r_out_valid;
    t_tok_out           r_out;
    logic               w_load, w_last;
    t_tok_res           w_res;

    assign w_res  = i_head.bundle.res[r_idx];
    assign w_last = (ResCntW'(r_idx) == (i_head.bundle.num - 1'b1));
    assign w_load = i_head.valid && (!r_out_valid || i_out_ready);
    assign o_pop  = w_load && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx <= w_last ? '0 : r_idx + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.token_kind  <= w_res.kind;
            r_out.char_out    <= w_res.ch;
            r_out.token_count <= w_res.cnt;
            r_out.last_of_run <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
